### rtl/p4drp_pkg.sv
// ----------------------------------------------------------------------------
// p4drp_pkg: shared definitions for the 4D rotate and project pipeline
// Widths, register indices and the record that travels through the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package p4drp_pkg;

   localparam int COORD_W    = 16;
   localparam int TRIG_W     = 16;
   localparam int DIM_W      = 12;
   localparam int CHAN_W     = 9;
   localparam int COLOR_W    = 32;
   localparam int PIX_W      = 22;
   localparam int CSR_IDX_W  = 3;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

   // 2.5 in Q.12
   localparam int DEPTH_BIAS = 10240;

   // Screen coordinate bits, positive depth bits and the numerator that
   // covers quotient times depth.
   localparam int QUO_W = $clog2(MAX_DIM);
   localparam int ZZ_W  = 19;
   localparam int NUM_W = ZZ_W + QUO_W;

   localparam logic [CSR_IDX_W-1:0] REG_SIN_XZ = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COS_XZ = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_XW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COS_XW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_YW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COS_YW = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd7;

   typedef struct packed {
      logic [NUM_W-1:0]   num_x;
      logic [NUM_W-1:0]   num_y;
      logic [ZZ_W-1:0]    den;
      logic [QUO_W-1:0]   qx;
      logic [QUO_W-1:0]   qy;
      logic               ok;
      logic [COLOR_W-1:0] color;
      logic               last;
   } div_type;

endpackage

`default_nettype wire

### rtl/p4drp_div.sv
// ----------------------------------------------------------------------------
// p4drp_div: pipelined restoring divider for both screen coordinates
// One quotient bit per stage; the x and y numerators share the depth divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module p4drp_div (
   input  wire logic                        clock,
   input  wire logic [p4drp_pkg::QUO_W-1:0] en,
   input  wire p4drp_pkg::div_type          div_in,
   output p4drp_pkg::div_type               div_out
);
   import p4drp_pkg::*;

   div_type div_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - 1 - s;
      div_type          prev;
      div_type          stage_in;
      logic [NUM_W-1:0] dsh;

      if (s == 0) begin : g_first
         assign prev = div_in;
      end else begin : g_next
         assign prev = div_ff[s-1];
      end

      always_comb begin
         stage_in = prev;
         dsh      = NUM_W'(prev.den) << K;
         if (prev.num_x >= dsh) begin
            stage_in.num_x = prev.num_x - dsh;
            stage_in.qx[K] = 1'b1;
         end
         if (prev.num_y >= dsh) begin
            stage_in.num_y = prev.num_y - dsh;
            stage_in.qy[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            div_ff[s] <= stage_in;
         end
      end
   end

   assign div_out = div_ff[QUO_W-1];

endmodule

`default_nettype wire

### rtl/point_4d_rotate_project.sv
// ----------------------------------------------------------------------------
// point_4d_rotate_project: 4D rotation and perspective projection of points
// Rotates each point in the XZ, XW and YW planes, projects it onto the frame
// and returns the pixel index, a visible flag and the packed colour.
// ----------------------------------------------------------------------------
// The block takes one point request in every clock cycle while the output is
// not held back and returns one result request for each, in order. The first
// nine stages do the three plane rotations, the depth offset and the scaling
// products, with the multiplications in stages 0, 2, 4 and 6 and a register
// after each stage; the next eleven stages are the restoring divider, one
// quotient bit per stage for x and y together, the longest part of the
// pipeline; the last stage forms row times width plus column. Every stage has
// its own valid bit and may load whenever it is empty or its successor moves,
// so bubbles close up and a held output stalls only as far back as needed.
// Configuration registers are read live and should be written only while no
// request is in flight.
`default_nettype none

module point_4d_rotate_project (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Point requests.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // coord_x, coord_y, coord_z, coord_w (16 bits each), red_in, green_in,
   // blue_in, alpha_in (9 bits each), four zero bits.
   input  wire logic [103:0]                    req_tdata,
   input  wire logic                            req_tlast,   // last_point
   // Result requests.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pixel_index (22 bits), packed_color (32 bits), two zero bits.
   output      logic [55:0]                     rsp_tdata,
   output      logic                            rsp_tuser,   // visible
   output      logic                            rsp_tlast,   // last_out
   // Register writes.
   input  wire logic                            csr_we,
   input  wire logic [p4drp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                     csr_wdata
);
   import p4drp_pkg::*;

   localparam int DIV_FIRST = 9;
   localparam int NSTG      = DIV_FIRST + QUO_W + 1;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic signed [TRIG_W-1:0] sin_xz_ff, cos_xz_ff, sin_xw_ff, cos_xw_ff;
   logic signed [TRIG_W-1:0] sin_yw_ff, cos_yw_ff;
   logic [DIM_W-1:0]         width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_xz_ff <= '0;
         cos_xz_ff <= TRIG_W'(16384);
         sin_xw_ff <= '0;
         cos_xw_ff <= TRIG_W'(16384);
         sin_yw_ff <= '0;
         cos_yw_ff <= TRIG_W'(16384);
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            REG_SIN_XZ: sin_xz_ff <= csr_wdata;
            REG_COS_XZ: cos_xz_ff <= csr_wdata;
            REG_SIN_XW: sin_xw_ff <= csr_wdata;
            REG_COS_XW: cos_xw_ff <= csr_wdata;
            REG_SIN_YW: sin_yw_ff <= csr_wdata;
            REG_COS_YW: cos_yw_ff <= csr_wdata;
            REG_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // The frame size is clamped to the largest supported frame.
   logic [DIM_W-1:0]   wd, ht;
   logic [DIM_W-2:0]   half_w, half_h;
   logic signed [12:0] wd_s, ht_s, half_w_s, half_h_s;

   assign wd       = (width_ff  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_ff;
   assign ht       = (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
   assign half_w   = wd[DIM_W-1:1];
   assign half_h   = ht[DIM_W-1:1];
   assign wd_s     = {1'b0, wd};
   assign ht_s     = {1'b0, ht};
   assign half_w_s = {2'b00, half_w};
   assign half_h_s = {2'b00, half_h};

   // ------------------------------------------------------------------
   // Stage enables: a stage loads when it is empty or its successor moves.
   // ------------------------------------------------------------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_tready = en[0];

   // ------------------------------------------------------------------
   // Stage 0: XZ products, the W products and the Y value that wait, colour bytes.
   // ------------------------------------------------------------------
   function automatic logic [7:0] color_byte(input logic [CHAN_W-1:0] c);
      logic [16:0] p;
      p = {c, 8'h00} - 17'(c);
      return (p[16:8] > 9'd255) ? 8'hFF : p[15:8];
   endfunction

   logic signed [COORD_W-1:0] in_x, in_y, in_z, in_w;
   assign in_x = req_tdata[15:0];
   assign in_y = req_tdata[31:16];
   assign in_z = req_tdata[47:32];
   assign in_w = req_tdata[63:48];

   logic signed [31:0] xc0_in, zs0_in, xs0_in, zc0_in, wc0_in, ws0_in;
   logic signed [31:0] xc0_ff, zs0_ff, xs0_ff, zc0_ff, wc0_ff, ws0_ff;
   logic signed [COORD_W-1:0] y0_ff;
   logic [COLOR_W-1:0] color_in;
   logic [COLOR_W-1:0] color0_ff, color1_ff, color2_ff, color3_ff, color4_ff;
   logic [COLOR_W-1:0] color5_ff, color6_ff, color7_ff, color8_ff;
   logic last0_ff, last1_ff, last2_ff, last3_ff, last4_ff, last5_ff, last6_ff;
   logic last7_ff, last8_ff;

   assign xc0_in = in_x * cos_xz_ff;
   assign zs0_in = in_z * sin_xz_ff;
   assign xs0_in = in_x * sin_xz_ff;
   assign zc0_in = in_z * cos_xz_ff;
   assign wc0_in = in_w * cos_xw_ff;
   assign ws0_in = in_w * sin_xw_ff;
   assign color_in = {color_byte(req_tdata[99:91]), color_byte(req_tdata[90:82]),
                      color_byte(req_tdata[81:73]), color_byte(req_tdata[72:64])};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xc0_ff    <= xc0_in;
         zs0_ff    <= zs0_in;
         xs0_ff    <= xs0_in;
         zc0_ff    <= zc0_in;
         wc0_ff    <= wc0_in;
         ws0_ff    <= ws0_in;
         y0_ff     <= in_y;
         color0_ff <= color_in;
         last0_ff  <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: XZ rotation sums, floored to Q.12.
   // ------------------------------------------------------------------
   logic signed [32:0] dx1, dz1;
   logic signed [18:0] tx1_ff, tz1_ff;
   logic signed [31:0] wc1_ff, ws1_ff;
   logic signed [COORD_W-1:0] y1_ff;

   assign dx1 = 33'(xc0_ff) - 33'(zs0_ff);
   assign dz1 = 33'(xs0_ff) + 33'(zc0_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tx1_ff    <= dx1[32:14];
         tz1_ff    <= dz1[32:14];
         wc1_ff    <= wc0_ff;
         ws1_ff    <= ws0_ff;
         y1_ff     <= y0_ff;
         color1_ff <= color0_ff;
         last1_ff  <= last0_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: XW products and the Y product of the YW rotation.
   // ------------------------------------------------------------------
   logic signed [34:0] txs2_in, txc2_in, txs2_ff, txc2_ff;
   logic signed [31:0] yc2_in, yc2_ff, wc2_ff, ws2_ff;
   logic signed [18:0] tz2_ff;

   assign txs2_in = tx1_ff * sin_xw_ff;
   assign txc2_in = tx1_ff * cos_xw_ff;
   assign yc2_in  = y1_ff * cos_yw_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         txs2_ff   <= txs2_in;
         txc2_ff   <= txc2_in;
         yc2_ff    <= yc2_in;
         wc2_ff    <= wc1_ff;
         ws2_ff    <= ws1_ff;
         tz2_ff    <= tz1_ff;
         color2_ff <= color1_ff;
         last2_ff  <= last1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: XW rotation sums and the biased depth.
   // ------------------------------------------------------------------
   logic signed [35:0] dw3, dx3;
   logic signed [21:0] tw3_ff, tx3_ff;
   logic signed [19:0] zz3_in, zz3_ff;
   logic signed [31:0] yc3_ff;

   assign dw3    = 36'(txs2_ff) + 36'(wc2_ff);
   assign dx3    = 36'(txc2_ff) - 36'(ws2_ff);
   assign zz3_in = 20'(tz2_ff) + 20'(DEPTH_BIAS);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         tw3_ff    <= dw3[35:14];
         tx3_ff    <= dx3[35:14];
         zz3_ff    <= zz3_in;
         yc3_ff    <= yc2_ff;
         color3_ff <= color2_ff;
         last3_ff  <= last2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: YW product and the screen scaling products.
   // ------------------------------------------------------------------
   logic signed [37:0] tws4_in, tws4_ff;
   logic signed [34:0] txw4_in, txw4_ff;
   logic signed [31:0] hwz4_in, hwz4_ff, hhz4_in, hhz4_ff, yc4_ff;
   logic signed [32:0] wz4_in, wz4_ff, hz4_in, hz4_ff;
   logic signed [19:0] zz4_ff;

   assign tws4_in = tw3_ff * sin_yw_ff;
   assign txw4_in = tx3_ff * wd_s;
   assign hwz4_in = zz3_ff * half_w_s;
   assign hhz4_in = zz3_ff * half_h_s;
   assign wz4_in  = zz3_ff * wd_s;
   assign hz4_in  = zz3_ff * ht_s;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         tws4_ff   <= tws4_in;
         txw4_ff   <= txw4_in;
         hwz4_ff   <= hwz4_in;
         hhz4_ff   <= hhz4_in;
         wz4_ff    <= wz4_in;
         hz4_ff    <= hz4_in;
         yc4_ff    <= yc3_ff;
         zz4_ff    <= zz3_ff;
         color4_ff <= color3_ff;
         last4_ff  <= last3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: YW rotation sum and the x numerator.
   // ------------------------------------------------------------------
   logic signed [38:0] dy5;
   logic signed [24:0] ty5_ff;
   logic signed [35:0] xnum5_in, xnum5_ff;
   logic signed [31:0] hhz5_ff;
   logic signed [32:0] wz5_ff, hz5_ff;
   logic signed [19:0] zz5_ff;

   assign dy5      = 39'(yc4_ff) - 39'(tws4_ff);
   assign xnum5_in = 36'(txw4_ff) + 36'(hwz4_ff);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         ty5_ff    <= dy5[38:14];
         xnum5_ff  <= xnum5_in;
         hhz5_ff   <= hhz4_ff;
         wz5_ff    <= wz4_ff;
         hz5_ff    <= hz4_ff;
         zz5_ff    <= zz4_ff;
         color5_ff <= color4_ff;
         last5_ff  <= last4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: y scaling product and the x range test. The quotient lies in
   // the frame exactly when minus depth < numerator < width times depth; a
   // numerator in the negative part of that range truncates to column zero.
   // ------------------------------------------------------------------
   logic signed [37:0] tyh6_in, tyh6_ff;
   logic               xok6_in, xok6_ff;
   logic [NUM_W-1:0]   xn6_in, xn6_ff;
   logic signed [31:0] hhz6_ff;
   logic signed [32:0] hz6_ff;
   logic signed [19:0] zz6_ff;

   assign tyh6_in = ty5_ff * ht_s;
   assign xok6_in = (zz5_ff > 20'sd0) && ((xnum5_ff + 36'(zz5_ff)) > 36'sd0) &&
                    (xnum5_ff < 36'(wz5_ff));
   assign xn6_in  = (xnum5_ff > 36'sd0) ? xnum5_ff[NUM_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         tyh6_ff   <= tyh6_in;
         xok6_ff   <= xok6_in;
         xn6_ff    <= xn6_in;
         hhz6_ff   <= hhz5_ff;
         hz6_ff    <= hz5_ff;
         zz6_ff    <= zz5_ff;
         color6_ff <= color5_ff;
         last6_ff  <= last5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: y numerator.
   // ------------------------------------------------------------------
   logic signed [38:0] ynum7_in, ynum7_ff;
   logic               xok7_ff;
   logic [NUM_W-1:0]   xn7_ff;
   logic signed [32:0] hz7_ff;
   logic signed [19:0] zz7_ff;

   assign ynum7_in = 39'(tyh6_ff) + 39'(hhz6_ff);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         ynum7_ff  <= ynum7_in;
         xok7_ff   <= xok6_ff;
         xn7_ff    <= xn6_ff;
         hz7_ff    <= hz6_ff;
         zz7_ff    <= zz6_ff;
         color7_ff <= color6_ff;
         last7_ff  <= last6_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: y range test; the record for the divider is formed here.
   // ------------------------------------------------------------------
   logic    yok8;
   div_type div8_in, div8_ff, div_out;

   assign yok8 = ((ynum7_ff + 39'(zz7_ff)) > 39'sd0) && (ynum7_ff < 39'(hz7_ff));

   always_comb begin
      div8_in.num_x = xn7_ff;
      div8_in.num_y = (ynum7_ff > 39'sd0) ? ynum7_ff[NUM_W-1:0] : '0;
      div8_in.den   = zz7_ff[ZZ_W-1:0];
      div8_in.qx    = '0;
      div8_in.qy    = '0;
      div8_in.ok    = xok7_ff && yok8;
      div8_in.color = color7_ff;
      div8_in.last  = last7_ff;
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         div8_ff <= div8_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 9 to 19: division by the depth, one quotient bit per stage.
   // ------------------------------------------------------------------
   p4drp_div u_div (
      .clock   (clock),
      .en      (en[DIV_FIRST +: QUO_W]),
      .div_in  (div8_ff),
      .div_out (div_out)
   );

   // ------------------------------------------------------------------
   // Output stage: pixel index from row and column.
   // ------------------------------------------------------------------
   logic [PIX_W-1:0]   lin;
   logic [PIX_W-1:0]   idx_in, idx_ff;
   logic [COLOR_W-1:0] color_out_ff;
   logic               seen_ff, last_out_ff;

   assign lin    = PIX_W'(div_out.qy) * PIX_W'(wd) + PIX_W'(div_out.qx);
   assign idx_in = div_out.ok ? lin : '0;

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         idx_ff       <= idx_in;
         color_out_ff <= div_out.color;
         seen_ff      <= div_out.ok;
         last_out_ff  <= div_out.last;
      end
   end

   assign rsp_tvalid = v_ff[NSTG-1];
   assign rsp_tdata  = {2'b00, color_out_ff, idx_ff};
   assign rsp_tuser  = seen_ff;
   assign rsp_tlast  = last_out_ff;

endmodule

`default_nettype wire
